### design/sha256_pkg.sv
// Package with SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

    localparam int BlockBytes = 64;
    localparam int BlockWords = 16;
    localparam int Rounds     = 64;
    localparam int QueueDepth = 4;

    // One beat of the front-to-back queue: a full block or a final block.
    typedef struct packed {
        logic [511:0] block;
        logic         last;
    } sha_job_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        begin
            case (idx)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        begin
            return (x >> n) | (x << (32 - n));
        end
    endfunction

endpackage
`default_nettype wire

### design/sha256_if.sv
// Valid/ready channel interfaces for byte input and digest output.
`timescale 1ns / 1ps
`default_nettype none
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

### design/sha256_byte_stream_hasher_top.sv
// Top level of the SHA-256 byte stream hasher.
// Bytes are taken one per cycle, unless a block-completing byte finds the
// queue full or the front end is padding, and packed into 64-byte blocks;
// each full block goes into a four-entry queue, and the compression engine
// runs one round per cycle. Byte intake keeps running while the engine works
// until the queue is full. The end-of-message beat adds one or two padded
// blocks, and the eight digest words then leave one per cycle while the
// receiver is ready, index 0 first, with last_word set on index 7.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sha256_in_if.sink    in_ch,
    sha256_out_if.source out_ch
);
    import sha256_pkg::*;

    sha_job_t front_job, back_job;
    logic     front_valid, front_ready, back_valid, back_ready;

    sha256_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    sha256_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_job   (front_job),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_job   (back_job),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    sha256_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .out_ch    (out_ch)
    );
endmodule
`default_nettype wire

### design/sha256_front.sv
// Front end: packs bytes into blocks and builds the padded final blocks.
`timescale 1ns / 1ps
`default_nettype none
module sha256_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    sha256_in_if.sink              in_ch,
    output sha256_pkg::sha_job_t   job,
    output logic                   job_valid,
    input  wire logic              job_ready
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_TAKE  = 3'b001,
        ST_PAD   = 3'b010,
        ST_LEN   = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [511:0] buf_reg, buf_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;

    logic [5:0]   wr_pos;
    logic [511:0] with_byte;
    logic [511:0] padded;
    logic [5:0]   fill_after;

    // Byte insertion at the current fill point (big-endian order).
    always_comb
    begin
        wr_pos = fill_reg;
        with_byte = buf_reg;
        with_byte[511 - 8 * wr_pos -: 8] = in_ch.data_byte;
        fill_after = fill_reg + 6'(in_ch.has_byte);
    end

    // Padding of a partial block: 0x80 at the fill point, zeros after.
    function automatic logic [511:0] pad_block(input logic [511:0] b, input logic [5:0] f);
        logic [511:0] r;
        begin
            r = b;
            for (int i = 0; i < BlockBytes; i++)
            begin
                if (6'(i) == f)
                    r[511 - 8 * i -: 8] = 8'h80;
                else if (6'(i) > f)
                    r[511 - 8 * i -: 8] = 8'h00;
            end
            return r;
        end
    endfunction

    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        in_ch.ready = 1'b0;
        job_valid  = 1'b0;
        job.block  = buf_reg;
        job.last   = 1'b0;
        padded     = pad_block(buf_reg, fill_reg);
        case (state_reg)
            ST_TAKE:
            begin
                // A byte that completes a block needs a queue slot.
                in_ch.ready = !(in_ch.has_byte && fill_reg == 6'd63) || job_ready;
                job.block = with_byte;
                if (in_ch.valid && in_ch.ready)
                begin
                    if (in_ch.has_byte)
                    begin
                        buf_next  = with_byte;
                        fill_next = fill_after;
                        bits_next = bits_reg + 64'd8;
                        if (fill_reg == 6'd63)
                            job_valid = 1'b1;
                    end
                    if (in_ch.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg >= 6'd56)
                begin
                    job.block = padded;
                    job_valid = 1'b1;
                    if (job_ready)
                    begin
                        buf_next = '0;
                        state_next = ST_LEN;
                    end
                end
                else
                begin
                    buf_next = padded;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                job.block = {buf_reg[511:64], bits_reg};
                job.last  = 1'b1;
                job_valid = 1'b1;
                if (job_ready)
                begin
                    fill_next  = '0;
                    bits_next  = '0;
                    state_next = ST_TAKE;
                end
            end
            default: state_next = ST_TAKE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TAKE;
            fill_reg  <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end
endmodule
`default_nettype wire

### design/sha256_queue.sv
// Short block queue between the front end and the compression engine.
`timescale 1ns / 1ps
`default_nettype none
module sha256_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sha256_pkg::sha_job_t wr_job,
    input  wire logic                 wr_valid,
    output logic                      wr_ready,
    output sha256_pkg::sha_job_t      rd_job,
    output logic                      rd_valid,
    input  wire logic                 rd_ready
);
    import sha256_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    sha_job_t          mem_reg [QueueDepth];
    logic [PtrW-1:0]   wptr_reg, rptr_reg;
    logic [PtrW:0]     count_reg;
    logic              push, pop;

    assign wr_ready = count_reg != (PtrW+1)'(QueueDepth);
    assign rd_valid = count_reg != '0;
    assign rd_job   = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

### design/sha256_core.sv
// Back end: one SHA-256 round per cycle, then digest word output after a final block.
`timescale 1ns / 1ps
`default_nettype none
module sha256_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sha256_pkg::sha_job_t job,
    input  wire logic                 job_valid,
    output logic                      job_ready,
    sha256_out_if.source              out_ch
);
    import sha256_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_EMIT  = 4'b1000
    } core_state_t;

    core_state_t  state_reg, state_next;
    logic [255:0] hash_reg, hash_next;
    logic [255:0] work_reg, work_next;
    logic [511:0] sched_reg, sched_next;
    logic [5:0]   round_reg, round_next;
    logic [2:0]   word_reg, word_next;
    logic         last_reg, last_next;

    logic [31:0] a, b, c, d, e, f, g, h, w0, t1, t2, s0, s1, w_new;
    logic [31:0] w1, w9, w14;

    // Round datapath and message schedule (16-word window).
    always_comb
    begin
        {a, b, c, d, e, f, g, h} = work_reg;
        w0  = sched_reg[511:480];
        w1  = sched_reg[479:448];
        w9  = sched_reg[223:192];
        w14 = sched_reg[63:32];
        t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
             + round_k(round_reg) + w0;
        t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        s0 = ror32(w1, 7) ^ ror32(w1, 18) ^ (w1 >> 3);
        s1 = ror32(w14, 17) ^ ror32(w14, 19) ^ (w14 >> 10);
        w_new = w0 + s0 + w9 + s1;
    end

    always_comb
    begin
        state_next = state_reg;
        hash_next  = hash_reg;
        work_next  = work_reg;
        sched_next = sched_reg;
        round_next = round_reg;
        word_next  = word_reg;
        last_next  = last_reg;
        job_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    work_next  = hash_reg;
                    sched_next = job.block;
                    last_next  = job.last;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                work_next  = {t1 + t2, a, b, c, d + t1, e, f, g};
                sched_next = {sched_reg[479:0], w_new};
                round_next = round_reg + 1'b1;
                if (round_reg == 6'(Rounds - 1))
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    hash_next[32*i +: 32] = hash_reg[32*i +: 32] + work_reg[32*i +: 32];
                word_next  = '0;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    word_next = word_reg + 1'b1;
                    if (word_reg == 3'd7)
                    begin
                        hash_next  = InitHash;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_ch.valid       = state_reg == ST_EMIT;
    assign out_ch.digest_word = hash_reg[255 - 32 * word_reg -: 32];
    assign out_ch.word_index  = word_reg;
    assign out_ch.last_word   = word_reg == 3'd7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hash_reg  <= InitHash;
            round_reg <= '0;
            word_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            round_reg <= round_next;
            word_reg  <= word_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        sched_reg <= sched_next;
    end
endmodule
`default_nettype wire

### design/sha256_checker.sv
// Port-level checks on the hasher, attached to the top level by bind.
`timescale 1ns / 1ps
`default_nettype none
module sha256_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);
    // The last flag marks exactly index seven.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    // Taken words step through the index in order.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=> (out_valid &&
        word_index == $past(word_index) + 3'd1))
        else $error("digest words not consecutive");

    // A stalled word holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(digest_word)
        && $stable(word_index)))
        else $error("stalled digest word changed");
endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .last_word   (out_ch.last_word)
);
`default_nettype wire

### sim/tb.sv
// Testbench for the SHA-256 byte stream hasher: directed table, padding boundaries and random messages.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import sha256_pkg::*;

    typedef struct {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        end_of_message;
        logic        has_known;
        logic [31:0] known_first;
    } stim_row_t;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    localparam logic [31:0] EmptyDigestW0 = 32'he3b0c442;
    localparam logic [31:0] AbcDigestW0   = 32'hba7816bf;
    localparam int          ItemCount     = 480;
    localparam int          PadLens [4]   = '{55, 56, 63, 64};

    logic clk;
    logic rst_n;
    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_byte_stream_hasher_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predictor state: running hash state of the message under way.
    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    int unsigned  block_fill;
    logic [63:0]  bit_count;
    digest_beat_t digest_queue [$];
    int           mismatches;
    int           directed_first_left;
    logic [31:0]  directed_first_word;
    int           beats_sent;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_reinit();
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = InitHash[255 - 32 * i -: 32];
        end
        block_fill = 0;
        bit_count  = '0;
    endtask

    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hash_state[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = hash_state[i] + v[i];
        end
    endtask

    // Advance the predictor by one accepted input beat and queue any digest words.
    task automatic predict_digest(input logic [7:0] b, input logic hb, input logic eom);
        digest_beat_t d;
        if (hb)
        begin
            msg_block[block_fill] = b;
            bit_count  = bit_count + 64'd8;
            block_fill = (block_fill + 1) % 64;
            if (block_fill == 0)
                compress_msg_block();
        end
        if (eom)
        begin
            msg_block[block_fill] = 8'h80;
            for (int i = block_fill + 1; i < 64; i++)
                msg_block[i] = 8'h00;
            if (block_fill >= 56)
            begin
                compress_msg_block();
                for (int i = 0; i < 56; i++)
                    msg_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                msg_block[56 + i] = bit_count[63 - 8*i -: 8];
            compress_msg_block();
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash_state[i];
                d.word_index  = i[2:0];
                d.last_word   = (i == 7);
                digest_queue.insert(digest_queue.size(), d);
            end
            hash_reinit();
        end
    endtask

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
    end
    always #5 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Overall time limit.
    initial
    begin
        #20ms;
        $display("FAIL sha256_byte_stream_hasher_top");
        $finish;
    end

    // Receiver: stalls on a rotating pattern with stall-free stretches.
    initial
    begin
        int phase;
        out_ch.ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            phase = (phase + 1) % 97;
            if (phase < 30)
                out_ch.ready <= 1'b1;
            else if (phase < 60)
                out_ch.ready <= (phase % 3) != 0;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Digest checker on accepted output beats.
    always @(posedge clk)
    begin
        digest_beat_t exp_beat;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (digest_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest beat: word %h index %0d",
                             out_ch.digest_word, out_ch.word_index);
            end
            else
            begin
                exp_beat = digest_queue.pop_front();
                if (out_ch.digest_word !== exp_beat.digest_word
                    || out_ch.word_index !== exp_beat.word_index
                    || out_ch.last_word !== exp_beat.last_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp_beat.digest_word, exp_beat.word_index,
                                 exp_beat.last_word, out_ch.digest_word,
                                 out_ch.word_index, out_ch.last_word);
                end
                // Typed-in first words of known digests from the directed table.
                if (directed_first_left > 0 && exp_beat.word_index == 3'd0)
                begin
                    directed_first_left--;
                    if (directed_first_word !== 32'hx
                        && out_ch.digest_word !== directed_first_word)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("known digest mismatch: exp %h got %h",
                                     directed_first_word, out_ch.digest_word);
                    end
                end
            end
        end
    end

    // Sender: one beat, held until accepted, with predictor update at acceptance.
    task automatic send_beat(input logic [7:0] b, input logic hb, input logic eom);
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.has_byte       <= hb;
        in_ch.end_of_message <= eom;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_digest(b, hb, eom);
        beats_sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin
        stim_row_t table_rows [12];
        stim_row_t r;
        int burst;
        int msg_len;
        int kind;
        int wait_cycles;

        in_ch.valid          = 1'b0;
        in_ch.data_byte      = 8'h00;
        in_ch.has_byte       = 1'b0;
        in_ch.end_of_message = 1'b0;
        mismatches           = 0;
        directed_first_left  = 0;
        directed_first_word  = 32'hx;
        beats_sent           = 0;
        hash_reinit();

        // Directed table: empty message, idle beat, "abc", extremes, end with byte.
        table_rows = '{
            '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigestW0},
            '{8'h5a, 1'b0, 1'b0, 1'b0, 32'h0},
            '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'h63, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'hff, 1'b0, 1'b1, 1'b1, AbcDigestW0},
            '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
            '{8'h80, 1'b1, 1'b1, 1'b0, 32'h0},
            '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
            '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0}};

        @(posedge rst_n);
        @(posedge clk);
        foreach (table_rows[i])
        begin
            r = table_rows[i];
            if (r.has_known)
            begin
                in_ch.valid <= 1'b0;
                wait (digest_queue.size() == 0);
                @(posedge clk);
                directed_first_word = r.known_first;
                directed_first_left = 1;
            end
            send_beat(r.data_byte, r.has_byte, r.end_of_message);
            if (r.has_known)
            begin
                in_ch.valid <= 1'b0;
                wait (digest_queue.size() == 0);
                @(posedge clk);
                directed_first_word = 32'hx;
            end
        end

        // Padding boundaries: lengths 55, 56, 63 and 64.
        foreach (PadLens[i])
        begin
            for (int j = 0; j < PadLens[i]; j++)
                send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_beat(8'h00, 1'b0, 1'b1);
        end

        // Random messages in bursts with gaps; mostly short, a few long.
        burst = $urandom_range(1, 20);
        while (beats_sent < ItemCount)
        begin
            kind = $urandom_range(0, 9);
            msg_len = (kind < 7) ? int'($urandom_range(0, 20)) : int'($urandom_range(50, 140));
            if (msg_len > ItemCount - beats_sent)
                msg_len = ItemCount - beats_sent;
            for (int j = 0; j <= msg_len; j++)
            begin
                if (burst == 0)
                begin
                    idle_gap($urandom_range(0, 1) ? $urandom_range(1, 6) : 0);
                    burst = $urandom_range(1, 40);
                end
                burst--;
                if (j == msg_len)
                    send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                else if ($urandom_range(0, 15) == 0)
                    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                else
                    send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
        end
        in_ch.valid <= 1'b0;

        // Drain: wait for all digest words, then a short settle time.
        wait_cycles = 0;
        while (digest_queue.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (mismatches == 0 && digest_queue.size() == 0)
            $display("PASS sha256_byte_stream_hasher_top");
        else
            $display("FAIL sha256_byte_stream_hasher_top");
        $finish;
    end
endmodule
`default_nettype wire

### sha256_byte_stream_hasher_top.f
design/sha256_pkg.sv
design/sha256_if.sv
design/sha256_front.sv
design/sha256_queue.sv
design/sha256_core.sv
design/sha256_byte_stream_hasher_top.sv
design/sha256_checker.sv
sim/tb.sv
